// ----- rtl/core/ebaf_pkg.sv -----
// shared types, constants and neighbour helpers for the background activity filter
package ebaf_pkg;

  localparam int COORD_W     = 8;
  localparam int TS_W        = 32;
  localparam int SHIFT_W     = 4;
  localparam int MAP_COLUMNS = 256;
  localparam int MAP_ROWS    = 256;
  localparam int MAP_ENTRIES = MAP_COLUMNS * MAP_ROWS;
  localparam int ADDR_W      = $clog2(MAP_ENTRIES);
  localparam int NB_COUNT    = 8;
  localparam int NB_IDX_W    = $clog2(NB_COUNT);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int DATA_W      = 2 * COORD_W + TS_W;

  localparam logic [TS_W-1:0]    DELTA_T_RESET     = 32'd30000;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET       = '0;
  localparam logic [COORD_W-1:0] LAST_COLUMN_RESET = 8'd255;
  localparam logic [COORD_W-1:0] LAST_ROW_RESET    = 8'd255;

  typedef enum logic [1:0] {
    CFG_DELTA_T,
    CFG_SUBSAMPLE_SHIFT,
    CFG_LAST_COLUMN,
    CFG_LAST_ROW
  } cfg_idx_t;

  typedef enum logic [1:0] {
    STEP_NONE,
    STEP_INC,
    STEP_DEC
  } step_t;

  // neighbour order: left, right, up, down, then the four diagonals
  localparam step_t NB_DX [NB_COUNT] = '{STEP_DEC, STEP_INC, STEP_NONE, STEP_NONE,
                                         STEP_DEC, STEP_INC, STEP_DEC, STEP_INC};
  localparam step_t NB_DY [NB_COUNT] = '{STEP_NONE, STEP_NONE, STEP_DEC, STEP_INC,
                                         STEP_DEC, STEP_INC, STEP_INC, STEP_DEC};

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_WRITE,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    logic                act;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [NB_COUNT-1:0] nb_mask;
    logic [COORD_W-1:0]  column;
    logic [COORD_W-1:0]  row;
    logic [TS_W-1:0]     timestamp;
  } cmd_t;

  function automatic logic [COORD_W-1:0] nb_coord(input logic [COORD_W-1:0] c,
                                                   input step_t s);
    logic [COORD_W-1:0] r;
    case (s)
      STEP_INC: r = c + 1'b1;
      STEP_DEC: r = c - 1'b1;
      default:  r = c;
    endcase
    return r;
  endfunction

  // neighbour lies inside the bounds along one axis
  function automatic logic nb_in_range(input logic [COORD_W-1:0] c,
                                       input logic [COORD_W-1:0] lim,
                                       input step_t s);
    logic ok;
    case (s)
      STEP_INC: ok = (c < lim);
      STEP_DEC: ok = (c != '0);
      default:  ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

// ----- rtl/core/ebaf_ram.sv -----
// generic single-port ram with registered read
module ebaf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/ebaf_front.sv -----
// front end: takes input items, subsamples, bounds-checks and builds neighbour masks
module ebaf_front (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ebaf_pkg::DATA_W-1:0]   in_tdata,
  input  logic                          in_tuser,
  input  logic                          enable,
  input  logic [ebaf_pkg::SHIFT_W-1:0]  shift,
  input  logic [ebaf_pkg::COORD_W-1:0]  last_column,
  input  logic [ebaf_pkg::COORD_W-1:0]  last_row,
  input  logic                          q_full,
  output logic                          q_push,
  output ebaf_pkg::cmd_t                q_data
);
  import ebaf_pkg::*;

  logic [COORD_W-1:0]  column;
  logic [COORD_W-1:0]  row;
  logic [TS_W-1:0]     timestamp;
  logic [COORD_W-1:0]  x;
  logic [COORD_W-1:0]  y;
  logic                act;
  logic [NB_COUNT-1:0] mask;

  assign column    = in_tdata[COORD_W-1:0];
  assign row       = in_tdata[2*COORD_W-1:COORD_W];
  assign timestamp = in_tdata[DATA_W-1:2*COORD_W];

  assign x   = column >> shift;
  assign y   = row >> shift;
  // the map covers all 8-bit coordinates, so the bounds need no saturation
  assign act = in_tuser && (x <= last_column) && (y <= last_row);

  always_comb begin
    for (int k = 0; k < NB_COUNT; k++) begin
      mask[k] = nb_in_range(x, last_column, NB_DX[k]) && nb_in_range(y, last_row, NB_DY[k]);
    end
  end

  assign in_tready = enable && !q_full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    q_data           = '0;
    q_data.act       = act;
    q_data.x         = x;
    q_data.y         = y;
    q_data.nb_mask   = act ? mask : '0;
    q_data.column    = column;
    q_data.row       = row;
    q_data.timestamp = timestamp;
  end

endmodule

// ----- rtl/core/ebaf_queue.sv -----
// short command queue between front end and back end
module ebaf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ebaf_pkg::cmd_t push_data,
  input  logic           pop,
  output ebaf_pkg::cmd_t pop_data,
  output logic           full,
  output logic           empty
);
  import ebaf_pkg::*;

  cmd_t               entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]    count_r, count_nxt;

  assign full     = (count_r == QUEUE_DEPTH[QPTR_W:0]);
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/core/ebaf_back.sv -----
// back end: map clear, support check, neighbour stamp writes and result register
module ebaf_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ebaf_pkg::cmd_t                q_data,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  logic [ebaf_pkg::TS_W-1:0]     delta_t,
  output logic                          ram_we,
  output logic [ebaf_pkg::ADDR_W-1:0]   ram_addr,
  output logic [ebaf_pkg::TS_W-1:0]     ram_wdata,
  input  logic [ebaf_pkg::TS_W-1:0]     ram_rdata,
  output logic                          clearing,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ebaf_pkg::DATA_W-1:0]   out_tdata,
  output logic                          out_tuser
);
  import ebaf_pkg::*;

  bk_state_t           state_r, state_nxt;
  cmd_t                cmd_r;
  logic [NB_IDX_W-1:0] nb_cnt_r, nb_cnt_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic                keep_r, keep_nxt;
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_data_r;
  logic                out_keep_r;
  logic                out_free;
  logic                out_load;
  logic                take;
  logic                last_nb;
  logic [TS_W-1:0]     age;
  logic                supported;
  logic [COORD_W-1:0]  nb_x;
  logic [COORD_W-1:0]  nb_y;

  assign out_free  = !out_valid_r || out_tready;
  assign last_nb   = (nb_cnt_r == NB_IDX_W'(NB_COUNT - 1));
  assign age       = cmd_r.timestamp - ram_rdata;
  assign supported = (ram_rdata != '0) && (age < delta_t);
  assign nb_x      = nb_coord(cmd_r.x, NB_DX[nb_cnt_r]);
  assign nb_y      = nb_coord(cmd_r.y, NB_DY[nb_cnt_r]);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: begin
        if (clr_cnt_r == ADDR_W'(MAP_ENTRIES - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_data.act ? BK_READ : BK_DONE;
        end
      end
      BK_READ:  state_nxt = BK_WRITE;
      BK_WRITE: begin
        if (last_nb) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          if (q_empty) begin
            state_nxt = BK_IDLE;
          end else begin
            state_nxt = q_data.act ? BK_READ : BK_DONE;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    clearing  = 1'b0;
    out_load  = 1'b0;
    take      = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = {cmd_r.x, cmd_r.y};
    ram_wdata = cmd_r.timestamp;
    case (state_r)
      BK_CLEAR: begin
        clearing  = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_r;
        ram_wdata = '0;
      end
      BK_IDLE:  take = !q_empty;
      BK_READ:  ram_addr = {cmd_r.x, cmd_r.y};
      BK_WRITE: begin
        ram_we   = cmd_r.nb_mask[nb_cnt_r];
        ram_addr = {nb_x, nb_y};
      end
      BK_DONE: begin
        out_load = out_free;
        take     = out_free && !q_empty;
      end
      default: ;
    endcase
  end

  assign q_pop = take;

  always_comb begin
    nb_cnt_nxt  = nb_cnt_r;
    clr_cnt_nxt = clr_cnt_r;
    keep_nxt    = keep_r;
    if (state_r == BK_CLEAR) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
    end
    if (state_r == BK_READ) begin
      nb_cnt_nxt = '0;
    end
    if (state_r == BK_WRITE) begin
      nb_cnt_nxt = nb_cnt_r + 1'b1;
      // stamp read on the previous edge is on the ram output in the first write cycle
      if (nb_cnt_r == '0) begin
        keep_nxt = supported;
      end
    end
    if (take) begin
      keep_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    nb_cnt_r <= nb_cnt_nxt;
    keep_r   <= keep_nxt;
    if (take) begin
      cmd_r <= q_data;
    end
    if (out_load) begin
      out_data_r <= {cmd_r.timestamp, cmd_r.row, cmd_r.column};
      out_keep_r <= keep_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_keep_r;

endmodule

// ----- rtl/core/event_background_activity_filter.sv -----
// top level of the background activity filter: config registers, front, queue, back, map
// each valid in-bounds event takes one map read, eight neighbour write slots on the single
//   map port and one result load; an invalid or out-of-bounds event goes straight to the
//   result load; the result load waits while the previous result is held by out_tready
// reset: synchronous active-low; afterwards the map is zeroed by a clearing pass,
//   one entry a cycle, during which no input item is accepted
module event_background_activity_filter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [ebaf_pkg::DATA_W-1:0]          in_tdata,   // column, row, timestamp
  input  logic                                 in_tuser,   // event_valid
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [ebaf_pkg::DATA_W-1:0]          out_tdata,  // column_out, row_out, timestamp_out
  output logic                                 out_tuser,  // keep
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [ebaf_pkg::TS_W-1:0]            cfg_wdata
);
  import ebaf_pkg::*;

  logic [TS_W-1:0]    delta_t_r;
  logic [SHIFT_W-1:0] shift_r;
  logic [COORD_W-1:0] last_column_r;
  logic [COORD_W-1:0] last_row_r;

  cmd_t               push_data;
  cmd_t               pop_data;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  logic               clearing;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [TS_W-1:0]    ram_wdata;
  logic [TS_W-1:0]    ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_t_r     <= DELTA_T_RESET;
      shift_r       <= SHIFT_RESET;
      last_column_r <= LAST_COLUMN_RESET;
      last_row_r    <= LAST_ROW_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DELTA_T:         delta_t_r     <= cfg_wdata;
        CFG_SUBSAMPLE_SHIFT: shift_r       <= cfg_wdata[SHIFT_W-1:0];
        CFG_LAST_COLUMN:     last_column_r <= cfg_wdata[COORD_W-1:0];
        CFG_LAST_ROW:        last_row_r    <= cfg_wdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  ebaf_front u_front (
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .enable      (!clearing),
    .shift       (shift_r),
    .last_column (last_column_r),
    .last_row    (last_row_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (push_data)
  );

  ebaf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  ebaf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_data     (pop_data),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .delta_t    (delta_t_r),
    .ram_we     (ram_we),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .ram_rdata  (ram_rdata),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  ebaf_ram #(
    .WIDTH (TS_W),
    .DEPTH (MAP_ENTRIES)
  ) u_stamp_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // no item taken while the map is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_tready)
    else $error("input accepted during map clear");

  // the clearing pass starts straight out of reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> clearing)
    else $error("map clear not running after reset");

  // no result can exist before the map is clean
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_tvalid)
    else $error("result presented during map clear");

  // a clear write never carries a stamp
  a_clear_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> ram_we && (ram_wdata == '0))
    else $error("clear pass not writing zero");

endmodule
